// ----- rtl/core/rmd_pkg.sv -----
// Shared types, codes and constants of the RPC record mark deframer.
`default_nettype none

package rmd_pkg;

  // Queue depth between the front part and the back part, and of the result queue.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_FRAGMENT_LIMIT = 1'b0;
  localparam logic REG_RECORD_LIMIT   = 1'b1;

  localparam logic [30:0] FRAGMENT_LIMIT_RESET = 31'd1048576;
  localparam logic [31:0] RECORD_LIMIT_RESET   = 32'd4194304;

  // Record mark layout.
  localparam int MARK_LAST_BIT = 31;
  localparam logic [1:0] MARK_FINAL_BYTE = 2'd3;

  // Input kinds.
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  // Result kinds.
  localparam logic [1:0] RK_PAYLOAD    = 2'd0;
  localparam logic [1:0] RK_EMPTY_END  = 2'd1;
  localparam logic [1:0] RK_ERROR      = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_FRAGMENT_LEN = 3'd1;
  localparam logic [2:0] ERR_RECORD_LEN   = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED    = 3'd3;
  localparam logic [2:0] ERR_EOS_AT_MARK  = 3'd4;

  typedef struct packed {
    logic       kind;
    logic [7:0] stream_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
    logic       record_end;
    logic [2:0] error_code;
  } result_t;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_EOS  = 1'b1
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_FAILED  = 2'd2
  } phase_t;

endpackage

`default_nettype wire

// ----- rtl/core/rmd_fifo.sv -----
// Small flop-based first-in first-out queue used between and after the deframer parts.
`default_nettype none

module rmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rmd_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  // DEPTH must be a power of two, at least 2, so the pointers wrap on their own.
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rmd_front.sv -----
// Front part: accepts stream items, classifies them into commands and queues them.
`default_nettype none

module rmd_front #(
  parameter int DEPTH = rmd_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rmd_pkg::item_t item,
  output logic               full,
  output logic               cmd_valid,
  output rmd_pkg::cmd_t      cmd,
  input  wire logic          cmd_take
);

  rmd_pkg::cmd_t cmd_in;
  logic          cmd_empty;

  // An end-of-stream item carries no byte; its data field is cleared.
  always_comb begin
    if (item.kind == rmd_pkg::KIND_EOS) begin
      cmd_in.op   = rmd_pkg::CMD_EOS;
      cmd_in.data = 8'd0;
    end else begin
      cmd_in.op   = rmd_pkg::CMD_DATA;
      cmd_in.data = item.stream_byte;
    end
  end

  rmd_fifo #(
    .WIDTH($bits(rmd_pkg::cmd_t)),
    .DEPTH(DEPTH)
  ) u_cmd_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(cmd_in),
    .full (full),
    .pop  (cmd_take),
    .rdata(cmd),
    .empty(cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

// ----- rtl/core/rmd_back.sv -----
// Back part: record mark parser, limit checks and payload pass-through.
`default_nettype none

module rmd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  input  wire rmd_pkg::cmd_t     cmd,
  output logic                   cmd_take,
  input  wire logic [30:0]       fragment_limit,
  input  wire logic [31:0]       record_limit,
  input  wire logic              res_full,
  output logic                   res_push,
  output rmd_pkg::result_t       res
);

  rmd_pkg::phase_t phase, phase_next;
  logic [1:0]  mark_count, mark_count_next;
  logic [23:0] mark_acc, mark_acc_next;
  logic        final_frag, final_frag_next;
  logic [30:0] bytes_rem, bytes_rem_next;
  logic [31:0] record_total, record_total_next;

  logic [31:0] mark;
  logic [30:0] frag_len;
  logic        frag_last;
  logic [32:0] total_sum;
  logic        frag_too_long;
  logic        rec_too_long;
  logic        mark_done;
  logic        is_eos;

  assign cmd_take = cmd_valid && !res_full;
  assign is_eos   = (cmd.op == rmd_pkg::CMD_EOS);

  assign mark          = {mark_acc, cmd.data};
  assign frag_len      = mark[30:0];
  assign frag_last     = mark[rmd_pkg::MARK_LAST_BIT];
  assign total_sum     = {1'b0, record_total} + {2'b00, frag_len};
  assign frag_too_long = (frag_len > fragment_limit);
  assign rec_too_long  = (total_sum > {1'b0, record_limit});
  assign mark_done     = (mark_count == rmd_pkg::MARK_FINAL_BYTE);

  // Next state.
  always_comb begin
    phase_next        = phase;
    mark_count_next   = mark_count;
    mark_acc_next     = mark_acc;
    final_frag_next   = final_frag;
    bytes_rem_next    = bytes_rem;
    record_total_next = record_total;
    if (cmd_take) begin
      unique case (phase)
        rmd_pkg::PH_HEADER: begin
          if (is_eos) begin
            phase_next = rmd_pkg::PH_FAILED;
          end else if (!mark_done) begin
            mark_acc_next   = {mark_acc[15:0], cmd.data};
            mark_count_next = mark_count + 2'd1;
          end else begin
            mark_acc_next   = 24'd0;
            mark_count_next = 2'd0;
            if (frag_too_long || rec_too_long) begin
              phase_next = rmd_pkg::PH_FAILED;
            end else if (frag_len == 31'd0) begin
              if (frag_last) begin
                record_total_next = 32'd0;
              end
            end else begin
              record_total_next = total_sum[31:0];
              bytes_rem_next    = frag_len;
              final_frag_next   = frag_last;
              phase_next        = rmd_pkg::PH_PAYLOAD;
            end
          end
        end
        rmd_pkg::PH_PAYLOAD: begin
          if (is_eos) begin
            phase_next = rmd_pkg::PH_FAILED;
          end else begin
            bytes_rem_next = bytes_rem - 31'd1;
            if (bytes_rem == 31'd1) begin
              if (final_frag) begin
                record_total_next = 32'd0;
              end
              final_frag_next = 1'b0;
              phase_next      = rmd_pkg::PH_HEADER;
            end
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Result generation.
  always_comb begin
    res_push         = 1'b0;
    res.result_kind  = rmd_pkg::RK_PAYLOAD;
    res.payload_byte = 8'd0;
    res.record_end   = 1'b0;
    res.error_code   = rmd_pkg::ERR_NONE;
    if (cmd_take) begin
      unique case (phase)
        rmd_pkg::PH_HEADER: begin
          if (is_eos) begin
            res_push        = 1'b1;
            res.result_kind = rmd_pkg::RK_ERROR;
            res.error_code  = rmd_pkg::ERR_EOS_AT_MARK;
          end else if (mark_done) begin
            if (frag_too_long) begin
              res_push        = 1'b1;
              res.result_kind = rmd_pkg::RK_ERROR;
              res.error_code  = rmd_pkg::ERR_FRAGMENT_LEN;
            end else if (rec_too_long) begin
              res_push        = 1'b1;
              res.result_kind = rmd_pkg::RK_ERROR;
              res.error_code  = rmd_pkg::ERR_RECORD_LEN;
            end else if (frag_len == 31'd0 && frag_last) begin
              res_push        = 1'b1;
              res.result_kind = rmd_pkg::RK_EMPTY_END;
              res.record_end  = 1'b1;
            end
          end
        end
        rmd_pkg::PH_PAYLOAD: begin
          res_push = 1'b1;
          if (is_eos) begin
            res.result_kind = rmd_pkg::RK_ERROR;
            res.error_code  = rmd_pkg::ERR_TRUNCATED;
          end else begin
            res.payload_byte = cmd.data;
            res.record_end   = final_frag && (bytes_rem == 31'd1);
          end
        end
        default: begin
          res_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= rmd_pkg::PH_HEADER;
      mark_count   <= 2'd0;
      mark_acc     <= 24'd0;
      final_frag   <= 1'b0;
      bytes_rem    <= 31'd0;
      record_total <= 32'd0;
    end else begin
      phase        <= phase_next;
      mark_count   <= mark_count_next;
      mark_acc     <= mark_acc_next;
      final_frag   <= final_frag_next;
      bytes_rem    <= bytes_rem_next;
      record_total <= record_total_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rpc_record_mark_deframer_top.sv -----
// Top level of the RPC record mark deframer: configuration registers, front, back, result queue.
`default_nettype none

// Channel   Ports                                    Transfer when
// input     push, full, item (kind, stream_byte)     push && !full
// result    pop, empty, result (kind, byte, end,     pop && !empty
//           error_code)
// config    psel, penable, pwrite, paddr, pwdata,    psel && penable && pwrite && pready
//           prdata, pready
//
// The block sustains one input transfer per cycle while full is low, and at most one result
// per input item. An accepted item is registered in the command queue, taken by the back
// part, and its result is registered in the result queue before it shows on the ports.
// The back part handles one command per cycle while the result queue has room; its mark
// length check against both limits is combinational. When the result queue fills, the
// back part stalls and the command queue absorbs up to QUEUE_DEPTH items before full rises.
// Synchronous reset empties both queues, returns the parser to the header phase and
// loads the limit registers with their default values.

module rpc_record_mark_deframer_top #(
  parameter int QUEUE_DEPTH = rmd_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  input  wire rmd_pkg::item_t                  item,
  output logic                                 full,
  input  wire logic                            pop,
  output rmd_pkg::result_t                     result,
  output logic                                 empty,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rmd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [rmd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [rmd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  // Configuration registers. Each register sits at a 4-byte step, so address bit 2
  // selects between them; the lower address bits are not decoded.
  logic [30:0] fragment_limit;
  logic [31:0] record_limit;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_limit <= rmd_pkg::FRAGMENT_LIMIT_RESET;
      record_limit   <= rmd_pkg::RECORD_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        rmd_pkg::REG_FRAGMENT_LIMIT: fragment_limit <= pwdata[30:0];
        rmd_pkg::REG_RECORD_LIMIT:   record_limit   <= pwdata;
        default:                     record_limit   <= record_limit;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rmd_pkg::REG_FRAGMENT_LIMIT: prdata = {1'b0, fragment_limit};
      rmd_pkg::REG_RECORD_LIMIT:   prdata = record_limit;
      default:                     prdata = '0;
    endcase
  end

  // The front part turns each input transfer into a command and holds it in a short
  // queue, so input transfers continue while the back part waits on the result side.
  logic          cmd_valid;
  rmd_pkg::cmd_t cmd;
  logic          cmd_take;

  rmd_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  // The back part parses record marks, checks the limits and produces results. It only
  // takes a command when the result queue has room for whatever that command produces.
  logic             res_full;
  logic             res_push;
  rmd_pkg::result_t res;

  rmd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take),
    .fragment_limit(fragment_limit),
    .record_limit  (record_limit),
    .res_full      (res_full),
    .res_push      (res_push),
    .res           (res)
  );

  // The result queue parts the back part from the consumer, so a result waiting for its
  // transfer does not stop the next command from being handled.
  rmd_fifo #(
    .WIDTH($bits(rmd_pkg::result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_result_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (pop),
    .rdata(result),
    .empty(empty)
  );

`ifndef ASSERT_OFF
  // A result is only produced when the result queue can take it.
  assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result produced while result queue is full");

  // Commands are only consumed when one is waiting.
  assert property (@(posedge clk) disable iff (rst) cmd_take |-> cmd_valid)
    else $error("command taken from an empty command queue");

  // After an error the parser is failed, so the following cycle produces nothing.
  assert property (@(posedge clk) disable iff (rst)
    (res_push && res.result_kind == rmd_pkg::RK_ERROR) |=> !res_push)
    else $error("result produced after an error");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/rpc_record_mark_deframer_top_test.sv -----
// Self-checking testbench for the RPC record mark deframer top level.
`timescale 1ns / 100ps

module rpc_record_mark_deframer_top_test;
  import rmd_pkg::*;

  // The run is cut off here if the traffic ever stops moving.
  localparam int CYCLE_LIMIT   = 400000;
  // Cycles that the receiver refuses results when a long hold is requested.
  localparam int LONG_HOLD     = 120;
  // Room for the path through both queues; an item with no result may still be in flight.
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PAYLOAD   = 12;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  item_t                 item = '0;
  logic                  full;
  logic                  pop = 1'b0;
  result_t               result;
  logic                  empty;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  rpc_record_mark_deframer_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .full    (full),
    .pop     (pop),
    .result  (result),
    .empty   (empty),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Items waiting to be offered, and results the deframer owes us, oldest first.
  item_t   pending_items[$];
  result_t expected_results[$];

  int unsigned cycle_count = 0;
  int          mismatch_count = 0;

  // The stimulus side bumps hold_req; the receiver notices the change and holds off.
  int hold_req = 0;
  int hold_seen = 0;

  int tx_wait = 0;
  int rx_wait = 0;
  int tx_gap;
  int rx_gap;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  // Our copy of the limit registers.
  logic [30:0] frag_limit = FRAGMENT_LIMIT_RESET;
  logic [31:0] rec_limit  = RECORD_LIMIT_RESET;

  // Our copy of the parser state.
  phase_t      parse_phase   = PH_HEADER;
  logic [1:0]  mark_count    = '0;
  logic [23:0] mark_prefix   = '0;
  logic        in_final_frag = 1'b0;
  logic [30:0] frag_left     = '0;
  logic [31:0] record_bytes  = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Most gaps are short, a few are long, and calm stretches have none at all.
  function automatic int draw_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic result_t error_result(input logic [2:0] code);
    result_t r;
    r = '0;
    r.result_kind = RK_ERROR;
    r.error_code  = code;
    return r;
  endfunction

  // Append one item to the stimulus queue.
  task automatic add_item(input item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Append one owed result to the expectation queue.
  task automatic owe_result(input result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  // Advance the parser copy by one accepted item and queue whatever result it owes.
  task automatic deframe_item(input item_t it);
    result_t     r;
    logic [31:0] mark;
    logic [30:0] len;
    // Once failed, nothing comes out until reset; the unused phase code acts the same.
    if (parse_phase != PH_HEADER && parse_phase != PH_PAYLOAD) return;
    r = '0;
    if (it.kind == KIND_EOS) begin
      // End of stream inside a payload is a truncation; anywhere in a mark it is an
      // end at the mark, even at a clean record boundary.
      owe_result(error_result(
          parse_phase == PH_PAYLOAD ? ERR_TRUNCATED : ERR_EOS_AT_MARK));
      parse_phase = PH_FAILED;
      return;
    end
    if (parse_phase == PH_HEADER) begin
      // The first three mark bytes are only collected.
      if (mark_count != MARK_FINAL_BYTE) begin
        mark_prefix = {mark_prefix[15:0], it.stream_byte};
        mark_count  = mark_count + 2'd1;
        return;
      end
      mark        = {mark_prefix, it.stream_byte};
      mark_count  = '0;
      mark_prefix = '0;
      len         = mark[30:0];
      // The fragment limit is checked first, so it wins when both are exceeded.
      if (len > frag_limit) begin
        owe_result(error_result(ERR_FRAGMENT_LEN));
        parse_phase = PH_FAILED;
      end else if (({1'b0, record_bytes} + {2'b0, len}) > {1'b0, rec_limit}) begin
        owe_result(error_result(ERR_RECORD_LEN));
        parse_phase = PH_FAILED;
      end else if (len == '0) begin
        // An empty last fragment closes the record with a marker; an empty middle
        // fragment is silently skipped.
        if (mark[MARK_LAST_BIT]) begin
          record_bytes  = '0;
          r.result_kind = RK_EMPTY_END;
          r.record_end  = 1'b1;
          owe_result(r);
        end
      end else begin
        record_bytes  = record_bytes + {1'b0, len};
        frag_left     = len;
        in_final_frag = mark[MARK_LAST_BIT];
        parse_phase   = PH_PAYLOAD;
      end
    end else begin
      r.result_kind  = RK_PAYLOAD;
      r.payload_byte = it.stream_byte;
      r.record_end   = (frag_left <= 31'd1) && in_final_frag;
      if (frag_left > '0) frag_left = frag_left - 31'd1;
      if (frag_left == '0) begin
        if (in_final_frag) record_bytes = '0;
        in_final_frag = 1'b0;
        parse_phase   = PH_HEADER;
      end
      owe_result(r);
    end
  endtask

  // Sender: offers the oldest pending item and predicts on every input transfer.
  // An offered item is held steady while full is high.
  always @(posedge clk) begin
    if (!rst) begin
      if (cycle_count[6:0] == 7'd0) tx_calm <= ($urandom_range(0, 3) == 0);
      if (push && full) begin
        // Keep offering the same item.
      end else if (tx_wait > 0) begin
        push    <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else begin
        if (push) begin
          deframe_item(item);
          pending_items.delete(0);
        end
        tx_gap = draw_gap(tx_calm);
        if (push && tx_gap > 0) begin
          push    <= 1'b0;
          tx_wait <= tx_gap - 1;
        end else if (pending_items.size() > 0) begin
          push <= 1'b1;
          item <= pending_items[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every result transfer against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (cycle_count[6:0] == 7'd64) rx_calm <= ($urandom_range(0, 3) == 0);
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.result_kind !== want.result_kind) begin
            $display("%0t: result_kind expected %0d actual %0d",
                     $time, want.result_kind, result.result_kind);
            mismatch_count++;
          end
          if (result.payload_byte !== want.payload_byte) begin
            $display("%0t: payload_byte expected %h actual %h",
                     $time, want.payload_byte, result.payload_byte);
            mismatch_count++;
          end
          if (result.record_end !== want.record_end) begin
            $display("%0t: record_end expected %0d actual %0d",
                     $time, want.record_end, result.record_end);
            mismatch_count++;
          end
          if (result.error_code !== want.error_code) begin
            $display("%0t: error_code expected %0d actual %0d",
                     $time, want.error_code, result.error_code);
            mismatch_count++;
          end
        end
      end
      if (rx_wait > 0) begin
        pop     <= 1'b0;
        rx_wait <= rx_wait - 1;
      end else if (hold_seen != hold_req) begin
        // Long hold: the deframer backs up and eventually raises full.
        hold_seen <= hold_req;
        pop       <= 1'b0;
        rx_wait   <= LONG_HOLD;
      end else if (pop && !empty) begin
        rx_gap = draw_gap(rx_calm);
        if (rx_gap > 0) begin
          pop     <= 1'b0;
          rx_wait <= rx_gap - 1;
        end else begin
          pop <= 1'b1;
        end
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic item_t make_item(input logic kind, input logic [7:0] data);
    item_t it;
    it.kind        = kind;
    it.stream_byte = data;
    return it;
  endfunction

  // A record mark goes out most significant byte first.
  task automatic queue_mark(input bit last, input logic [30:0] len);
    add_item(make_item(KIND_DATA, {last, len[30:24]}));
    add_item(make_item(KIND_DATA, len[23:16]));
    add_item(make_item(KIND_DATA, len[15:8]));
    add_item(make_item(KIND_DATA, len[7:0]));
  endtask

  task automatic queue_bytes(input int count);
    for (int i = 0; i < count; i++)
      add_item(make_item(KIND_DATA, 8'($urandom)));
  endtask

  task automatic queue_eos();
    add_item(make_item(KIND_EOS, 8'($urandom)));
  endtask

  // One well-formed record: a few fragments, the last one flagged, lengths kept inside
  // both limits and often right at the edge of what is allowed.
  task automatic queue_record();
    int     frags;
    int     len;
    longint room;
    longint total;
    frags = $urandom_range(1, 4);
    total = 0;
    for (int i = 0; i < frags; i++) begin
      room = longint'(frag_limit);
      if (longint'(rec_limit) - total < room) room = longint'(rec_limit) - total;
      if (MAX_PAYLOAD < room) room = MAX_PAYLOAD;
      len = ($urandom_range(0, 3) == 0) ? int'(room) : $urandom_range(0, int'(room));
      queue_mark(i == frags - 1, 31'(len));
      queue_bytes(len);
      total += len;
    end
  endtask

  task automatic queue_records(input int item_budget);
    int stop_at;
    stop_at = pending_items.size() + item_budget;
    while (pending_items.size() < stop_at) queue_record();
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] want);
    logic [CFG_DATA_W-1:0] got;
    apb_access(1'b0, addr, '0, got);
    if (got !== want) begin
      $display("%0t: register at %0d expected %h actual %h", $time, addr, want, got);
      mismatch_count++;
    end
  endtask

  // Registers may change only while the deframer is idle, so first let the sender run
  // dry, every owed result arrive and any trailing mark bytes settle.
  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_results.size() != 0 || push)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [31:0] frag_word, input logic [31:0] rec_word);
    logic [CFG_DATA_W-1:0] unused;
    wait_idle();
    apb_access(1'b1, {REG_FRAGMENT_LIMIT, 2'b00}, frag_word, unused);
    apb_access(1'b1, {REG_RECORD_LIMIT, 2'b00}, rec_word, unused);
    frag_limit = frag_word[30:0];
    rec_limit  = rec_word;
    check_reg({REG_FRAGMENT_LIMIT, 2'b00}, {1'b0, frag_limit});
    check_reg({REG_RECORD_LIMIT, 2'b00}, rec_limit);
  endtask

  // The parser fails for good on its first error, and reset happens only once, so a
  // single broken sequence closes the run; which one is chosen at random.
  task automatic queue_failure();
    int flavor;
    int len;
    flavor = $urandom_range(0, 5);
    case (flavor)
      0: begin
        // Fragment longer than its limit.
        queue_mark(1'($urandom_range(0, 1)), 31'($urandom_range(32'h7fffffff,
                                                                int'(frag_limit) + 1)));
      end
      1: begin
        // A full-size middle fragment, then one that overflows the record.
        queue_mark(1'b0, frag_limit);
        queue_bytes(int'(frag_limit));
        queue_mark(1'($urandom_range(0, 1)),
                   31'($urandom_range(int'(rec_limit) - int'(frag_limit) + 1,
                                      int'(frag_limit))));
      end
      2: begin
        // Both limits exceeded at once.
        queue_mark(1'b0, frag_limit);
        queue_bytes(int'(frag_limit));
        queue_mark(1'($urandom_range(0, 1)), frag_limit + 31'd1);
      end
      3: begin
        // Stream ends inside a payload.
        len = $urandom_range(1, int'(frag_limit));
        queue_mark(1'($urandom_range(0, 1)), 31'(len));
        queue_bytes($urandom_range(0, len - 1));
        queue_eos();
      end
      4: begin
        // Stream ends at a clean boundary, sometimes between fragments of a record.
        if ($urandom_range(0, 1) == 1) begin
          queue_mark(1'b0, 31'd2);
          queue_bytes(2);
        end
        queue_eos();
      end
      default: begin
        // Stream ends part way through a mark.
        queue_bytes($urandom_range(1, 3));
        queue_eos();
      end
    endcase
    // Anything after the failure must be swallowed without a result.
    for (int i = 0; i < 20; i++)
      add_item(make_item(1'($urandom_range(0, 1)), 8'($urandom)));
  endtask

  initial begin
    logic [30:0] small_frag;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset values of both limits.
    check_reg({REG_FRAGMENT_LIMIT, 2'b00}, {1'b0, FRAGMENT_LIMIT_RESET});
    check_reg({REG_RECORD_LIMIT, 2'b00}, RECORD_LIMIT_RESET);

    // Directed records at the default limits: an empty record end, a skipped empty
    // middle fragment, payload bytes at both extremes and a two-fragment record.
    queue_mark(1'b1, 31'd0);
    queue_mark(1'b0, 31'd0);
    queue_mark(1'b1, 31'd1);
    add_item(make_item(KIND_DATA, 8'h00));
    queue_mark(1'b0, 31'd2);
    add_item(make_item(KIND_DATA, 8'hff));
    add_item(make_item(KIND_DATA, 8'ha5));
    queue_mark(1'b1, 31'd1);
    add_item(make_item(KIND_DATA, 8'h5a));

    // Largest limits; a long receiver hold early on backs the whole block up.
    set_limits(32'h7fffffff, 32'hffffffff);
    queue_records(200);
    hold_req++;

    // Zero limits allow only empty fragments.
    set_limits(32'h00000000, $urandom);
    repeat (6) queue_record();
    set_limits(32'h7fffffff, 32'h00000000);
    repeat (6) queue_record();

    // Tight limits so records keep landing right on the boundaries.
    small_frag = 31'($urandom_range(1, 8));
    set_limits({1'b0, small_frag}, 32'($urandom_range(int'(small_frag), 24)));
    queue_records(200);

    // Arbitrary limits; bit 31 of the fragment limit write is dropped by the block.
    set_limits($urandom, $urandom);
    queue_records(200);

    // Limits that make every error reachable, then the closing broken sequence.
    small_frag = 31'($urandom_range(5, 8));
    set_limits({1'($urandom), small_frag},
               32'(small_frag) + 32'($urandom_range(0, 4)));
    repeat ($urandom_range(1, 3)) queue_record();
    queue_failure();

    while (pending_items.size() != 0 || expected_results.size() != 0 || push)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/rmd_pkg.sv
rtl/core/rmd_fifo.sv
rtl/core/rmd_front.sv
rtl/core/rmd_back.sv
rtl/core/rpc_record_mark_deframer_top.sv
tb/sv/rpc_record_mark_deframer_top_test.sv
